// ===== rtl/ttds_pkg.sv =====
// ----------------------------------------------------------------------------
// ttds_pkg
// Shared types and constants for the density-scaled trim throttle pipeline.
// ----------------------------------------------------------------------------
package ttds_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TRIM_THROTTLE = 3'd0;
  localparam logic [2:0] REG_THR_MIN_SPEED = 3'd1;
  localparam logic [2:0] REG_THR_MAX_SPEED = 3'd2;
  localparam logic [2:0] REG_SPEED_MIN     = 3'd3;
  localparam logic [2:0] REG_SPEED_TRIM    = 3'd4;
  localparam logic [2:0] REG_SPEED_MAX     = 3'd5;

  // register reset values
  localparam logic [15:0] RST_TRIM_THROTTLE = 16'd39321;
  localparam logic [15:0] RST_THR_MIN_SPEED = 16'd0;
  localparam logic [15:0] RST_THR_MAX_SPEED = 16'd0;
  localparam logic [15:0] RST_SPEED_MIN     = 16'd2560;
  localparam logic [15:0] RST_SPEED_TRIM    = 16'd3840;
  localparam logic [15:0] RST_SPEED_MAX     = 16'd5120;

  // density constants, Q2.14
  localparam logic [15:0] DENS_SEA_LEVEL = 16'd20070;
  localparam logic [15:0] DENS_FLOOR     = 16'd5962;

  // density numerator 1.225 * 2^32 split into preloaded remainder and
  // the low bits that give the 34-bit quotient
  localparam logic [46:0] DENS_NUM  = 47'(DENS_SEA_LEVEL) << 32;
  localparam int          DENS_QW   = 34;
  localparam logic [15:0] DENS_REM0 = 16'(DENS_NUM[46:DENS_QW]);
  localparam logic [DENS_QW-1:0] DENS_NUM_LO = DENS_NUM[DENS_QW-1:0];

  // scale limits, Q1.16
  localparam logic [16:0] SCALE_ONE = 17'd65536;
  localparam logic [16:0] SCALE_MAX = 17'd120246;

  // interpolation quotient width
  localparam int INTERP_QW = 33;

  // trim throttle saturated so that the final clamp gives the same word
  localparam int TSAT_W = 19;

  // sideband carried through the interpolation divider
  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] dens;
    logic [15:0] trim;
    logic        negate;
  } interp_side_t;

  // front stage contents
  typedef struct packed {
    interp_side_t side;
    logic [15:0]  abs_a;
    logic [15:0]  spd;
    logic [15:0]  abs_d;
  } front_t;

  // sideband carried through the density divider and square root
  typedef struct packed {
    logic [15:0]              lo;
    logic [15:0]              hi;
    logic signed [TSAT_W-1:0] tsat;
  } scale_side_t;

endpackage

// ===== rtl/ttds_div.sv =====
// ----------------------------------------------------------------------------
// ttds_div
// Pipelined restoring divider, STEP quotient bits per stage, with sideband.
// ----------------------------------------------------------------------------
module ttds_div #(
  parameter int DW   = 16,
  parameter int QW   = 33,
  parameter int STEP = 4,
  parameter int PW   = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);

  localparam int NS = (QW + STEP - 1) / STEP;

  logic [NS-1:0] v_q;
  logic [DW-1:0] r_q   [NS];
  logic [QW-1:0] w_q   [NS];
  logic [DW-1:0] den_q [NS];
  logic [PW-1:0] pay_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] r_i;
    logic [QW-1:0] w_i;
    logic [DW-1:0] den_i;
    logic [PW-1:0] pay_i;
    logic [DW-1:0] r_n;
    logic [QW-1:0] w_n;

    if (s == 0) begin : g_first
      assign v_i   = in_v;
      assign r_i   = in_rem;
      assign w_i   = in_num;
      assign den_i = in_den;
      assign pay_i = in_pay;
    end else begin : g_next
      assign v_i   = v_q[s-1];
      assign r_i   = r_q[s-1];
      assign w_i   = w_q[s-1];
      assign den_i = den_q[s-1];
      assign pay_i = pay_q[s-1];
    end

    // shift in one numerator bit per step, subtract where it fits
    always_comb begin
      logic [DW:0] t;
      r_n = r_i;
      w_n = w_i;
      t   = '0;
      for (int k = 0; k < STEP; k++) begin
        if (s * STEP + k < QW) begin
          t   = {r_n, w_n[QW-1]};
          w_n = {w_n[QW-2:0], 1'b0};
          if (t >= {1'b0, den_i}) begin
            t      = t - {1'b0, den_i};
            w_n[0] = 1'b1;
          end
          r_n = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_i;
      end
      if (en) begin
        r_q[s]   <= r_n;
        w_q[s]   <= w_n;
        den_q[s] <= den_i;
        pay_q[s] <= pay_i;
      end
    end
  end

  assign out_v   = v_q[NS-1];
  assign out_quo = w_q[NS-1];
  assign out_pay = pay_q[NS-1];

endmodule

// ===== rtl/ttds_sqrt.sv =====
// ----------------------------------------------------------------------------
// ttds_sqrt
// Pipelined digit-by-digit integer square root, STEP result bits per stage.
// ----------------------------------------------------------------------------
module ttds_sqrt #(
  parameter int K    = 17,
  parameter int STEP = 4,
  parameter int PW   = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [2*K-1:0] in_x,
  input  logic [PW-1:0]  in_pay,
  output logic           out_v,
  output logic [K-1:0]   out_root,
  output logic [PW-1:0]  out_pay
);

  localparam int NS = (K + STEP - 1) / STEP;

  logic [NS-1:0]  v_q;
  logic [2*K-1:0] x_q   [NS];
  logic [K:0]     rem_q [NS];
  logic [K-1:0]   res_q [NS];
  logic [PW-1:0]  pay_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic           v_i;
    logic [2*K-1:0] x_i;
    logic [K:0]     rem_i;
    logic [K-1:0]   res_i;
    logic [PW-1:0]  pay_i;
    logic [2*K-1:0] x_n;
    logic [K:0]     rem_n;
    logic [K-1:0]   res_n;

    if (s == 0) begin : g_first
      assign v_i   = in_v;
      assign x_i   = in_x;
      assign rem_i = '0;
      assign res_i = '0;
      assign pay_i = in_pay;
    end else begin : g_next
      assign v_i   = v_q[s-1];
      assign x_i   = x_q[s-1];
      assign rem_i = rem_q[s-1];
      assign res_i = res_q[s-1];
      assign pay_i = pay_q[s-1];
    end

    // two radicand bits per step against the trial 4*root+1
    always_comb begin
      logic [K+2:0] t;
      logic [K+2:0] trial;
      x_n   = x_i;
      rem_n = rem_i;
      res_n = res_i;
      t     = '0;
      trial = '0;
      for (int k = 0; k < STEP; k++) begin
        if (s * STEP + k < K) begin
          t     = {rem_n, x_n[2*K-1:2*K-2]};
          x_n   = {x_n[2*K-3:0], 2'b00};
          trial = {1'b0, res_n, 2'b01};
          if (t >= trial) begin
            t     = t - trial;
            res_n = {res_n[K-2:0], 1'b1};
          end else begin
            res_n = {res_n[K-2:0], 1'b0};
          end
          rem_n = t[K:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (en) begin
        v_q[s] <= v_i;
      end
      if (en) begin
        x_q[s]   <= x_n;
        rem_q[s] <= rem_n;
        res_q[s] <= res_n;
        pay_q[s] <= pay_i;
      end
    end
  end

  assign out_v    = v_q[NS-1];
  assign out_root = res_q[NS-1];
  assign out_pay  = pay_q[NS-1];

endmodule

// ===== rtl/trim_throttle_density_scaler.sv =====
// ----------------------------------------------------------------------------
// trim_throttle_density_scaler
// Pipeline: front stage, product stage, interpolation divider, density
// divider, square root, multiply register and output register; the divider
// and square root depths are set by DIV_STEP and SQRT_STEP. Throughput one
// word per cycle; a stalled output holds the whole pipeline. Reset clears all
// valid bits and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module trim_throttle_density_scaler
  import ttds_pkg::*;
#(
  parameter int DIV_STEP  = 4,
  parameter int SQRT_STEP = 4
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] throttle_lower,
  input  logic [15:0] throttle_upper,
  input  logic [15:0] speed_setpoint,
  input  logic        speed_valid,
  input  logic [15:0] density,
  input  logic        density_valid,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] throttle_out,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic en;

  // configuration registers
  logic [15:0] trim_throttle;
  logic [15:0] throttle_at_min_speed;
  logic [15:0] throttle_at_max_speed;
  logic [15:0] speed_minimum;
  logic [15:0] speed_trim;
  logic [15:0] speed_maximum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_throttle         <= RST_TRIM_THROTTLE;
      throttle_at_min_speed <= RST_THR_MIN_SPEED;
      throttle_at_max_speed <= RST_THR_MAX_SPEED;
      speed_minimum         <= RST_SPEED_MIN;
      speed_trim            <= RST_SPEED_TRIM;
      speed_maximum         <= RST_SPEED_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TRIM_THROTTLE: trim_throttle         <= cfg_data;
        REG_THR_MIN_SPEED: throttle_at_min_speed <= cfg_data;
        REG_THR_MAX_SPEED: throttle_at_max_speed <= cfg_data;
        REG_SPEED_MIN:     speed_minimum         <= cfg_data;
        REG_SPEED_TRIM:    speed_trim            <= cfg_data;
        REG_SPEED_MAX:     speed_maximum         <= cfg_data;
        default:           ;
      endcase
    end
  end

  // whole pipeline advances unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // front stage: pick the interpolation side and its spans
  front_t            a_next;
  logic              a_v;
  front_t            a_q;
  logic signed [16:0] a_lo, a_hi, d_lo, d_hi, a_sel, d_sel, a_abs, d_abs;
  logic              lower_sel, upper_sel;
  logic [15:0]       dens_sel;

  always_comb begin
    a_lo = signed'({1'b0, trim_throttle}) - signed'({1'b0, throttle_at_min_speed});
    a_hi = signed'({1'b0, throttle_at_max_speed}) - signed'({1'b0, trim_throttle});
    d_lo = signed'({1'b0, speed_trim}) - signed'({1'b0, speed_minimum});
    d_hi = signed'({1'b0, speed_maximum}) - signed'({1'b0, speed_trim});
    lower_sel = speed_valid && (throttle_at_min_speed != '0) &&
                (speed_trim != speed_minimum) && (speed_setpoint < speed_trim);
    upper_sel = !lower_sel && speed_valid && (throttle_at_max_speed != '0) &&
                (speed_maximum != speed_trim) && (speed_setpoint > speed_trim);
    a_sel = lower_sel ? a_lo : a_hi;
    d_sel = lower_sel ? d_lo : d_hi;
    a_abs = a_sel[16] ? -a_sel : a_sel;
    d_abs = d_sel[16] ? -d_sel : d_sel;

    // density fallback and floor
    dens_sel = density_valid ? density : DENS_SEA_LEVEL;
    if (dens_sel < DENS_FLOOR) begin
      dens_sel = DENS_FLOOR;
    end

    a_next.side.lo   = throttle_lower;
    a_next.side.hi   = throttle_upper;
    a_next.side.dens = dens_sel;
    a_next.side.trim = trim_throttle;
    if (lower_sel || upper_sel) begin
      a_next.abs_a = a_abs[15:0];
      a_next.abs_d = d_abs[15:0];
      a_next.spd   = lower_sel ? (speed_trim - speed_setpoint)
                               : (speed_setpoint - speed_trim);
      // lower side subtracts the rounded quotient
      a_next.side.negate = (a_sel[16] ^ d_sel[16]) ^ lower_sel;
    end else begin
      a_next.abs_a       = '0;
      a_next.abs_d       = 16'd1;
      a_next.spd         = '0;
      a_next.side.negate = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= in_valid;
    end
    if (en) begin
      a_q <= a_next;
    end
  end

  // product stage: rounded numerator for the interpolation divider
  logic                 b_v;
  logic [INTERP_QW-1:0] b_num;
  logic [15:0]          b_den;
  interp_side_t         b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
    if (en) begin
      b_num  <= INTERP_QW'(a_q.abs_a) * INTERP_QW'(a_q.spd) + INTERP_QW'(a_q.abs_d >> 1);
      b_den  <= a_q.abs_d;
      b_side <= a_q.side;
    end
  end

  // interpolation divider
  logic                 i_v;
  logic [INTERP_QW-1:0] i_quo;
  logic [$bits(interp_side_t)-1:0] i_pay;
  interp_side_t         i_side;

  ttds_div #(
    .DW   (16),
    .QW   (INTERP_QW),
    .STEP (DIV_STEP),
    .PW   ($bits(interp_side_t))
  ) u_interp_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (b_v),
    .in_rem  ('0),
    .in_num  (b_num),
    .in_den  (b_den),
    .in_pay  (b_side),
    .out_v   (i_v),
    .out_quo (i_quo),
    .out_pay (i_pay)
  );

  assign i_side = interp_side_t'(i_pay);

  // trim throttle, saturated where the clamp settles the word anyway
  localparam int TW = INTERP_QW + 2;
  localparam logic signed [TW-1:0] TSAT_HI = TW'(131072);
  localparam logic signed [TW-1:0] TSAT_LO = -TSAT_HI;

  logic signed [TW-1:0] t_full, q_ext;
  scale_side_t          s_side;

  always_comb begin
    q_ext  = signed'(TW'(i_quo));
    t_full = signed'(TW'(i_side.trim)) + (i_side.negate ? -q_ext : q_ext);
    s_side.lo = i_side.lo;
    s_side.hi = i_side.hi;
    if (t_full > TSAT_HI) begin
      s_side.tsat = TSAT_HI[TSAT_W-1:0];
    end else if (t_full < TSAT_LO) begin
      s_side.tsat = TSAT_LO[TSAT_W-1:0];
    end else begin
      s_side.tsat = t_full[TSAT_W-1:0];
    end
  end

  // density divider: 1.225 * 2^32 / density
  logic                dq_v;
  logic [DENS_QW-1:0]  dq_quo;
  logic [$bits(scale_side_t)-1:0] dq_pay;

  ttds_div #(
    .DW   (16),
    .QW   (DENS_QW),
    .STEP (DIV_STEP),
    .PW   ($bits(scale_side_t))
  ) u_dens_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_v    (i_v),
    .in_rem  (DENS_REM0),
    .in_num  (DENS_NUM_LO),
    .in_den  (i_side.dens),
    .in_pay  (s_side),
    .out_v   (dq_v),
    .out_quo (dq_quo),
    .out_pay (dq_pay)
  );

  // square root of the density ratio
  localparam int RK = DENS_QW / 2;

  logic          sq_v;
  logic [RK-1:0] sq_root;
  logic [$bits(scale_side_t)-1:0] sq_pay;
  scale_side_t   sq_side;

  ttds_sqrt #(
    .K    (RK),
    .STEP (SQRT_STEP),
    .PW   ($bits(scale_side_t))
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (dq_v),
    .in_x     (dq_quo),
    .in_pay   (dq_pay),
    .out_v    (sq_v),
    .out_root (sq_root),
    .out_pay  (sq_pay)
  );

  assign sq_side = scale_side_t'(sq_pay);

  // scale clamp and multiply
  localparam int PRW = TSAT_W + 18;

  logic [16:0]           scale;
  logic                  m_v;
  logic signed [PRW-1:0] m_prod;
  logic [15:0]           m_lo, m_hi;

  always_comb begin
    scale = 17'(sq_root);
    if (scale < SCALE_ONE) begin
      scale = SCALE_ONE;
    end else if (scale > SCALE_MAX) begin
      scale = SCALE_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (en) begin
      m_v <= sq_v;
    end
    if (en) begin
      m_prod <= PRW'(sq_side.tsat) * PRW'(signed'({1'b0, scale}));
      m_lo   <= sq_side.lo;
      m_hi   <= sq_side.hi;
    end
  end

  // rounding, ties away from zero, then clamp with the lower limit first
  logic [PRW-1:0]        mag;
  logic [PRW-1:0]        rmag;
  logic signed [PRW-1:0] rnd;
  logic [15:0]           res_word;

  always_comb begin
    mag  = m_prod[PRW-1] ? PRW'(-m_prod) : PRW'(m_prod);
    rmag = (mag + PRW'(32768)) >> 16;
    rnd  = m_prod[PRW-1] ? -signed'(rmag) : signed'(rmag);
    if (rnd < signed'(PRW'(m_lo))) begin
      res_word = m_lo;
    end else if (rnd > signed'(PRW'(m_hi))) begin
      res_word = m_hi;
    end else begin
      res_word = rnd[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= m_v;
    end
    if (en) begin
      throttle_out <= res_word;
    end
  end

endmodule
